// ===== hw/rtl/integer_deque_defines.svh =====
// Assertion macros used by the deque RTL.
`ifndef INTEGER_DEQUE_DEFINES_SVH
`define INTEGER_DEQUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define DQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");
// Next-cycle implication, disabled while in reset.
`define DQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int WORD_W      = 32;
    localparam int ACTION_W    = 3;
    localparam int ITEMS_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_PUSH_FRONT = 3'd0;
    localparam action_t ACT_PUSH_BACK  = 3'd1;
    localparam action_t ACT_POP_FRONT  = 3'd2;
    localparam action_t ACT_POP_BACK   = 3'd3;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK
    } op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        op_t   op;
        word_t push_value;
    } dq_cmd_t;

endpackage

// ===== hw/rtl/integer_deque.sv =====
// Double-ended queue of 32-bit signed integers, CAPACITY (16) entries deep, held in a
// row of cells with the front item always in the first cell. Every request accepted on
// s_axis returns exactly one result on m_axis; the result is registered in popped_reg and
// status_reg on acceptance and then in the output register, and a new request is taken every
// cycle as long as results are drained, since all cells of the row shift or load in the same
// cycle. Pops on an empty queue and pushes on a full one are refused with a status code and
// change nothing; action codes 5 to 7 behave as a query. No clearing pass is needed after reset.
`include "integer_deque_defines.svh"

module integer_deque (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] action, [34:3] push_value, [39:35] zero
    input  logic [dq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] popped_value, [36:32] items_held, [68:37] front_value,
    // [100:69] back_value, [102:101] status, [103] zero
    output logic [dq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import dq_pkg::*;

    action_t    action;
    word_t      push_value;
    logic       accept;
    logic       full;
    logic       empty;
    logic       out_free;
    logic       out_load;
    dq_cmd_t    cmd;
    status_t    status_next;
    word_t      popped_next;
    logic [CNT_W-1:0] count_next;
    word_t      back_word;
    word_t      front_word;

    logic [CNT_W-1:0] count_reg;
    logic       pend_reg;
    logic       out_valid_reg;
    word_t      popped_reg;
    status_t    status_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    word_t               cell_val [CAPACITY];
    word_t               cell_tap [CAPACITY];
    logic [CAPACITY-1:0] occ_vec;

    assign action     = s_axis_tdata[ACTION_W-1:0];
    assign push_value = s_axis_tdata[ACTION_W +: WORD_W];

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = pend_reg && out_free;
    assign s_axis_tready = !pend_reg || out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // Back item: the occupied cell whose right neighbor is free.
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_word = back_word | cell_tap[i];
        end
    end

    assign front_word = occ_vec[0] ? cell_val[0] : '0;

    always_comb
    begin
        cmd.op         = OP_NONE;
        cmd.push_value = push_value;
        status_next    = ST_DONE;
        popped_next    = '0;
        count_next     = count_reg;
        if (accept)
        begin
            unique case (action)
                ACT_PUSH_FRONT, ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = (action == ACT_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.op      = (action == ACT_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
                        popped_next = (action == ACT_POP_FRONT) ? cell_val[0] : back_word;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t left_val;
        logic  left_occ;
        word_t right_val;
        logic  right_occ;

        if (i == 0)
        begin : g_head
            assign left_val = push_value;
            assign left_occ = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[i-1];
            assign left_occ = occ_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_val = '0;
            assign right_occ = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[i+1];
            assign right_occ = occ_vec[i+1];
        end

        dq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_val  (left_val),
            .left_occ  (left_occ),
            .right_val (right_val),
            .right_occ (right_occ),
            .val       (cell_val[i]),
            .occ       (occ_vec[i]),
            .back_tap  (cell_tap[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
        // cells already reflect the pending transaction
        if (out_load)
        begin
            out_data_reg <= {1'b0, status_reg, back_word, front_word,
                             ITEMS_W'(count_reg), popped_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `DQ_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `DQ_ASSERT_IMP(a_occ_matches_count, clk, rst_n, 1'b1, $countones(occ_vec) == int'(count_reg))
    `DQ_ASSERT_IMP(a_occ_packed, clk, rst_n, 1'b1, ((occ_vec + 1'b1) & occ_vec) == '0)
    `DQ_ASSERT_NXT(a_refused_holds, clk, rst_n, accept && status_next != ST_DONE, $stable(count_reg))

endmodule

// ===== hw/rtl/dq_cell.sv =====
module dq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  dq_pkg::dq_cmd_t cmd,
    input  dq_pkg::word_t   left_val,
    input  logic            left_occ,
    input  dq_pkg::word_t   right_val,
    input  logic            right_occ,
    output dq_pkg::word_t   val,
    output logic            occ,
    output dq_pkg::word_t   back_tap
);
    import dq_pkg::*;

    word_t val_reg;
    word_t val_next;
    logic  occ_reg;
    logic  occ_next;

    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        unique case (cmd.op)
            OP_PUSH_FRONT:
            begin
                // shift toward the back
                val_next = left_val;
                occ_next = left_occ;
            end
            OP_POP_FRONT:
            begin
                // shift toward the front
                val_next = right_val;
                occ_next = right_occ;
            end
            OP_PUSH_BACK:
            begin
                // first free cell takes the value
                if (!occ_reg && left_occ)
                begin
                    val_next = cmd.push_value;
                    occ_next = 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (occ_reg && !right_occ)
                begin
                    occ_next = 1'b0;
                end
            end
            default:
            begin
                val_next = val_reg;
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val      = val_reg;
    assign occ      = occ_reg;
    assign back_tap = (occ_reg && !right_occ) ? val_reg : '0;

endmodule

// ===== verif/integer_deque_tb.sv =====
`timescale 1ns / 100ps

module integer_deque_tb;
    import dq_pkg::*;

    localparam action_t ACT_QUERY   = 3'd4;
    localparam action_t ACT_RSVD_LO = 3'd5;
    localparam action_t ACT_RSVD_HI = 3'd7;

    localparam word_t WORD_MAX = 32'h7FFF_FFFF;
    localparam word_t WORD_MIN = 32'h8000_0000;

    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int RANDOM_ITEMS = 1320;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_STALL   = 64;
    localparam int STALL_AT     = 300;
    localparam int PAUSE_AT     = 700;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        word_t              popped;
        logic [ITEMS_W-1:0] items;
        word_t              front_v;
        word_t              back_v;
        status_t            status;
    } deque_result_t;

    typedef struct {
        action_t       act;
        word_t         val;
        bit            typed;
        deque_result_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Mirror of the deque contents
    word_t              mirror_slots [CAPACITY];
    logic [SLOT_W-1:0]  mirror_head = '0;
    logic [ITEMS_W-1:0] mirror_count = '0;

    deque_result_t expected_results [$];
    stim_row_t     directed_rows [$];
    int            mismatch_count = 0;

    bit sender_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit long_stall_req = 1'b0;

    integer_deque u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [SLOT_W-1:0] slot_at(input logic [ITEMS_W-1:0] offset);
        slot_at = mirror_head + offset[SLOT_W-1:0];
    endfunction

    function automatic deque_result_t predict_request(input action_t act, input word_t val);
        deque_result_t r;
        r = '0;
        r.status = ST_DONE;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (mirror_count == ITEMS_W'(CAPACITY))
                begin
                    r.status = ST_FULL;
                end
                else if (act == ACT_PUSH_FRONT)
                begin
                    mirror_head = mirror_head - 1'b1;
                    mirror_slots[mirror_head] = val;
                    mirror_count = mirror_count + 1'b1;
                end
                else
                begin
                    mirror_slots[slot_at(mirror_count)] = val;
                    mirror_count = mirror_count + 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (mirror_count == '0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (act == ACT_POP_FRONT)
                begin
                    r.popped = mirror_slots[mirror_head];
                    mirror_head = mirror_head + 1'b1;
                    mirror_count = mirror_count - 1'b1;
                end
                else
                begin
                    r.popped = mirror_slots[slot_at(mirror_count - 1'b1)];
                    mirror_count = mirror_count - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.items = mirror_count;
        if (mirror_count != '0)
        begin
            r.front_v = mirror_slots[mirror_head];
            r.back_v = mirror_slots[slot_at(mirror_count - 1'b1)];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        end
    endtask

    task automatic add_row(input action_t act, input word_t val, input bit typed,
                           input word_t popped, input int items, input word_t front_v,
                           input word_t back_v, input status_t status);
        stim_row_t row;
        row.act = act;
        row.val = val;
        row.typed = typed;
        row.want.popped = popped;
        row.want.items = items[ITEMS_W-1:0];
        row.want.front_v = front_v;
        row.want.back_v = back_v;
        row.want.status = status;
        directed_rows.push_back(row);
    endtask

    // Call just after a falling edge; returns just after the falling edge that
    // follows acceptance of the transaction.
    task automatic drive_item(input action_t act, input word_t val, input bit typed,
                              input deque_result_t want);
        deque_result_t predicted;
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - ACTION_W - WORD_W){1'b0}}, val, act};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted = predict_request(act, val);
        expected_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Result side: compare every accepted transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no request outstanding",
                                          m_axis_tdata));
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("popped_value", m_axis_tdata[31:0], want.popped);
                check_field("items_held", 32'(m_axis_tdata[36:32]), 32'(want.items));
                check_field("front_value", m_axis_tdata[68:37], want.front_v);
                check_field("back_value", m_axis_tdata[100:69], want.back_v);
                check_field("status", 32'(m_axis_tdata[102:101]), 32'(want.status));
            end
        end
    end

    // Result side ready: short random bursts low, plus one long hold-off on request
    initial
    begin : sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                hold_left = LONG_STALL - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #200000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        bit        filling;
        action_t   act;
        word_t     val;
        int        r;

        foreach (mirror_slots[k])
        begin
            mirror_slots[k] = '0;
        end

        add_row(ACT_POP_FRONT, 32'h0000_0001, 1'b1, '0, 0, '0, '0, ST_EMPTY);
        add_row(ACT_POP_BACK, 32'hFFFF_FFFF, 1'b1, '0, 0, '0, '0, ST_EMPTY);
        add_row(ACT_QUERY, 32'hFFFF_FFFF, 1'b1, '0, 0, '0, '0, ST_DONE);
        add_row(ACT_RSVD_HI, WORD_MAX, 1'b1, '0, 0, '0, '0, ST_DONE);
        add_row(ACT_PUSH_BACK, WORD_MAX, 1'b1, '0, 1, WORD_MAX, WORD_MAX, ST_DONE);
        add_row(ACT_PUSH_FRONT, WORD_MIN, 1'b1, '0, 2, WORD_MIN, WORD_MAX, ST_DONE);
        add_row(ACT_RSVD_LO, 32'h1234_5678, 1'b1, '0, 2, WORD_MIN, WORD_MAX, ST_DONE);
        add_row(ACT_POP_BACK, '0, 1'b1, WORD_MAX, 1, WORD_MIN, WORD_MIN, ST_DONE);
        add_row(ACT_POP_FRONT, '0, 1'b1, WORD_MIN, 0, '0, '0, ST_DONE);
        // Fill to capacity, then push once more
        for (int k = 1; k <= CAPACITY; k++)
        begin
            add_row(ACT_PUSH_BACK, word_t'(k), 1'b0, '0, 0, '0, '0, ST_DONE);
        end
        add_row(ACT_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1, '0, CAPACITY, word_t'(1),
                word_t'(CAPACITY), ST_FULL);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            drive_item(row.act, row.val, row.typed, row.want);
        end

        // Alternate between filling and draining so that both limits are hit often
        filling = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sender_gaps = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 3 != 2)
                          && !(i >= STALL_AT && i < STALL_AT + 100);
            sink_gaps = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 4 != 1);
            if (i == STALL_AT)
            begin
                long_stall_req = 1'b1;
            end
            if (i == PAUSE_AT)
            begin
                s_axis_tvalid <= 1'b0;
                do
                begin
                    @(negedge clk);
                end
                while (expected_results.size() != 0);
            end
            if ($urandom_range(0, 23) == 0)
            begin
                filling = !filling;
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                act = action_t'($urandom_range(4, 7));
            else if (r < 50)
                act = filling ? ACT_PUSH_FRONT : ACT_POP_FRONT;
            else if (r < 90)
                act = filling ? ACT_PUSH_BACK : ACT_POP_BACK;
            else if (r < 95)
                act = filling ? ACT_POP_FRONT : ACT_PUSH_FRONT;
            else
                act = filling ? ACT_POP_BACK : ACT_PUSH_BACK;
            case ($urandom_range(0, 7))
                0: val = '0;
                1: val = WORD_MAX;
                2: val = WORD_MIN;
                3: val = '1;
                default: val = $urandom;
            endcase
            drive_item(act, val, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        // Catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
